FILE: rtl/hjg_pkg.sv
// Shared types and constants for the handwheel jog generator.
// No dependencies; used by hjg_ctrl, hjg_dp and the top level.
package hjg_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 10;
  localparam int unsigned FEED_W  = 16;
  localparam int unsigned DIST_W  = 8;
  localparam int unsigned QUOT_W  = 24;   // 255 * 60000 fits in 24 bits
  localparam int unsigned CNT_W   = $clog2(QUOT_W);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [FEED_W-1:0] MS_PER_MINUTE = 16'd60000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REV_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_FEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_FEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JOG_DIST   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [WIN_W-1:0]  RST_REV_WINDOW = 10'd50;
  localparam logic [FEED_W-1:0] RST_X_FEED     = 16'd1000;
  localparam logic [FEED_W-1:0] RST_Y_FEED     = 16'd1000;
  localparam logic [FEED_W-1:0] RST_Z_FEED     = 16'd600;
  localparam logic [DIST_W-1:0] RST_JOG_DIST   = 8'd1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Signed step codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic              clk_level;
    logic              dir_level;
    logic              x_button_n;
    logic              y_button_n;
    logic              z_button_n;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] step_dir;
    logic              jog_valid;
    logic [1:0]        jog_axis;
    logic              jog_negative;
    logic [FEED_W-1:0] jog_feed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take the input transaction
    logic div_step;  // one restoring division step
    logic div_last;  // final step: commit quotient as hold-off
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_blocked;  // result register full and stalled
    logic jog_fire;     // current input issues a jog
  } dp_status_t;

endpackage

FILE: rtl/hjg_ctrl.sv
// Controller for the handwheel jog generator: input handshake and
// division sequencing. Depends on hjg_pkg.
module hjg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hjg_pkg::dp_status_t status_i,
  output hjg_pkg::dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                       state_q, state_d;
  logic [hjg_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       accept;
  logic                       last_step;

  assign in_stall_o = (state_q == ST_DIV) | status_i.out_blocked;
  assign accept     = in_valid_i & ~in_stall_o;
  assign last_step  = (cnt_q == hjg_pkg::CNT_W'(hjg_pkg::QUOT_W - 1));

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept && status_i.jog_fire) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = last_step;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/hjg_dp.sv
// Datapath for the handwheel jog generator: configuration registers, step
// decode, jog state, result register and serial hold-off divider.
// Depends on hjg_pkg.
module hjg_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hjg_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hjg_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  hjg_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output hjg_pkg::out_item_t                   out_item_o,
  input  hjg_pkg::dp_cmd_t                     cmd_i,
  output hjg_pkg::dp_status_t                  status_o
);

  localparam int unsigned TW = hjg_pkg::TIME_W;
  localparam int unsigned FW = hjg_pkg::FEED_W;
  localparam int unsigned QW = hjg_pkg::QUOT_W;

  // Configuration
  logic [hjg_pkg::WIN_W-1:0]  win_q;
  logic [FW-1:0]              x_feed_q, y_feed_q, z_feed_q;
  logic [hjg_pkg::DIST_W-1:0] dist_q;

  // Jog state
  logic          prev_clk_q;
  logic [TW-1:0] last_edge_q;
  logic [1:0]    last_dir_q;
  logic [TW-1:0] last_jog_q;
  logic [QW-1:0] hold_off_q;

  // Divider
  logic [QW-1:0] dvd_q, dvd_d;
  logic [FW-1:0] rem_q, rem_d;
  logic [FW-1:0] dvs_q;
  logic [FW:0]   rem_sh;
  logic          q_bit;

  // Result register
  logic                out_valid_q;
  hjg_pkg::out_item_t  out_q, res;

  // Step decode
  logic          fall;
  logic [1:0]    dir_code;
  logic [TW-1:0] edge_elapsed, jog_elapsed;
  logic          dropped, stepped, hold_ok, sel;
  logic [1:0]    axis;
  logic [FW-1:0] feed;
  logic          fire;

  always_comb begin
    fall         = prev_clk_q & ~in_item_i.clk_level;
    dir_code     = in_item_i.dir_level ? hjg_pkg::DIR_POS : hjg_pkg::DIR_NEG;
    edge_elapsed = in_item_i.now_ms - last_edge_q;
    jog_elapsed  = in_item_i.now_ms - last_jog_q;
    dropped      = (edge_elapsed < TW'(win_q)) && (last_dir_q != dir_code);
    stepped      = fall & ~dropped;
    hold_ok      = jog_elapsed >= TW'(hold_off_q);

    sel  = 1'b1;
    axis = hjg_pkg::AXIS_X;
    feed = x_feed_q;
    if (!in_item_i.x_button_n) begin
      axis = hjg_pkg::AXIS_X;
      feed = x_feed_q;
    end else if (!in_item_i.y_button_n) begin
      axis = hjg_pkg::AXIS_Y;
      feed = y_feed_q;
    end else if (!in_item_i.z_button_n) begin
      axis = hjg_pkg::AXIS_Z;
      feed = z_feed_q;
    end else begin
      sel = 1'b0;
    end

    fire = stepped & hold_ok & sel & (feed != '0);

    res              = '0;
    res.step_dir     = stepped ? dir_code : hjg_pkg::DIR_NONE;
    res.jog_valid    = fire;
    res.jog_axis     = fire ? axis : hjg_pkg::AXIS_X;
    res.jog_negative = fire & ~in_item_i.dir_level;
    res.jog_feed     = fire ? feed : '0;
  end

  assign status_o.jog_fire    = fire;
  assign status_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_item_o           = out_q;

  // Restoring division, one quotient bit a step
  always_comb begin
    rem_sh = {rem_q, dvd_q[QW-1]};
    q_bit  = rem_sh >= {1'b0, dvs_q};
    rem_d  = q_bit ? FW'(rem_sh - {1'b0, dvs_q}) : rem_sh[FW-1:0];
    dvd_d  = {dvd_q[QW-2:0], q_bit};
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= hjg_pkg::RST_REV_WINDOW;
      x_feed_q <= hjg_pkg::RST_X_FEED;
      y_feed_q <= hjg_pkg::RST_Y_FEED;
      z_feed_q <= hjg_pkg::RST_Z_FEED;
      dist_q   <= hjg_pkg::RST_JOG_DIST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hjg_pkg::CFG_REV_WINDOW: win_q    <= cfg_wdata_i[hjg_pkg::WIN_W-1:0];
        hjg_pkg::CFG_X_FEED:     x_feed_q <= cfg_wdata_i[FW-1:0];
        hjg_pkg::CFG_Y_FEED:     y_feed_q <= cfg_wdata_i[FW-1:0];
        hjg_pkg::CFG_Z_FEED:     z_feed_q <= cfg_wdata_i[FW-1:0];
        hjg_pkg::CFG_JOG_DIST:   dist_q   <= cfg_wdata_i[hjg_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Jog state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_clk_q  <= 1'b1;
      last_edge_q <= '0;
      last_dir_q  <= hjg_pkg::DIR_NONE;
      last_jog_q  <= '0;
      hold_off_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        prev_clk_q <= in_item_i.clk_level;
        if (fall) begin
          last_edge_q <= in_item_i.now_ms;
        end
        if (stepped) begin
          last_dir_q <= dir_code;
        end
        if (fire) begin
          last_jog_q <= in_item_i.now_ms;
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_last) begin
        hold_off_q <= dvd_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= res;
      dvd_q <= QW'(dist_q) * QW'(hjg_pkg::MS_PER_MINUTE);
      dvs_q <= feed;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

FILE: rtl/handwheel_jog_generator.sv
// Handwheel jog generator: decodes encoder samples into rate-limited jogs.
// Top level; instantiates hjg_ctrl and hjg_dp, uses hjg_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_item_i): one transaction is
//    one sample of the encoder lines, the axis buttons and the ms timestamp.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//    result transaction per input transaction, in order.
//  - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at the
//    clock edge; write only while the block is idle. Unknown indexes are
//    ignored.
//  - Each result is registered and shown in the cycle after its input is taken.
//  - Sample handling: a sample that issues no jog leaves the input free for the
//    next sample. A sample that issues a jog starts the 24 steps of the serial
//    restoring divider that computes the hold-off, during which the input
//    stalls. The divider width is set by distance*60000, which fits 24 bits.
//  - A finished result waits in the output register; a new sample is taken
//    in the same cycle the held result is collected, unless the divider runs.
//  - When the receiver stalls, hold the result and stall the input.
//  - Reset (asynchronous, active low) restores the register defaults, clears
//    the edge and jog history and drops any pending result.
module handwheel_jog_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hjg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hjg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hjg_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hjg_pkg::out_item_t             out_item_o
);

  hjg_pkg::dp_cmd_t    cmd;
  hjg_pkg::dp_status_t status;

  // Sequence transactions and the divider
  hjg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Decode steps, hold the jog state, compute the hold-off
  hjg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

FILE: tb/tb_handwheel_jog_generator.sv
// Self-checking testbench for handwheel_jog_generator: encoder samples in, jog results out.
// Depends on hjg_pkg and the handwheel_jog_generator RTL; a built-in predictor checks results.
`timescale 1ns / 1ps

module tb_handwheel_jog_generator;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned DRAIN_CYCLES   = 40;    // covers the 24-step hold-off divider

  // One row of the directed table; typed rows carry a hand-worked result
  typedef struct {
    hjg_pkg::in_item_t  sample;
    bit                 typed;
    hjg_pkg::out_item_t result;
  } sample_row_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [hjg_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = hjg_pkg::CFG_REV_WINDOW;
  logic [hjg_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  hjg_pkg::in_item_t              in_item_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  hjg_pkg::out_item_t             out_item_o;

  handwheel_jog_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the edge/jog history
  // ---------------------------------------------------------------------------
  logic [hjg_pkg::WIN_W-1:0]  win_reg;
  logic [hjg_pkg::FEED_W-1:0] x_feed_reg, y_feed_reg, z_feed_reg;
  logic [hjg_pkg::DIST_W-1:0] dist_reg;
  logic                       seen_clk;
  logic [31:0]                edge_stamp;
  logic [1:0]                 kept_dir;      // DIR_NONE until a step is accepted
  logic [31:0]                jog_stamp;
  logic [31:0]                hold_off;

  hjg_pkg::out_item_t         expected_jogs[$];
  int unsigned                mismatches  = 0;
  int unsigned                quiet_cycles = 0;

  // Idling switches, changed per phase so that some stretches run flat out
  bit                         in_idle_on  = 1'b1;
  bit                         out_idle_on = 1'b1;

  // Encoder state used to build well-formed rotations in the random part
  logic                       enc_clk;
  logic                       enc_dir;
  logic [2:0]                 enc_btn_n;     // {x, y, z}, active low
  logic [31:0]                enc_ms;

  sample_row_t                sample_rows[$];

  task automatic reset_model();
    win_reg    = hjg_pkg::RST_REV_WINDOW;
    x_feed_reg = hjg_pkg::RST_X_FEED;
    y_feed_reg = hjg_pkg::RST_Y_FEED;
    z_feed_reg = hjg_pkg::RST_Z_FEED;
    dist_reg   = hjg_pkg::RST_JOG_DIST;
    seen_clk   = 1'b1;
    edge_stamp = '0;
    kept_dir   = hjg_pkg::DIR_NONE;
    jog_stamp  = '0;
    hold_off   = '0;
  endtask

  // Mirror a register write; unknown indexes fall through untouched
  task automatic model_reg_write(logic [hjg_pkg::CFG_IDX_W-1:0] idx,
                                 logic [hjg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      hjg_pkg::CFG_REV_WINDOW: win_reg    = data[hjg_pkg::WIN_W-1:0];
      hjg_pkg::CFG_X_FEED:     x_feed_reg = data;
      hjg_pkg::CFG_Y_FEED:     y_feed_reg = data;
      hjg_pkg::CFG_Z_FEED:     z_feed_reg = data;
      hjg_pkg::CFG_JOG_DIST:   dist_reg   = data[hjg_pkg::DIST_W-1:0];
      default: ;
    endcase
  endtask

  // Work out the result of one sample and advance the history
  function automatic hjg_pkg::out_item_t predict_jog(hjg_pkg::in_item_t s);
    hjg_pkg::out_item_t         r;
    logic [31:0]                jog_gap;
    logic [31:0]                edge_gap;
    logic [1:0]                 d;
    logic [1:0]                 axis;
    logic [hjg_pkg::FEED_W-1:0] feed;
    bit                         picked;
    r        = '0;
    jog_gap  = s.now_ms - jog_stamp;
    edge_gap = s.now_ms - edge_stamp;
    axis     = hjg_pkg::AXIS_X;
    feed     = '0;
    picked   = 1'b1;
    // Falling clock edge: a step, unless it is a quick reversal
    if (seen_clk && !s.clk_level) begin
      d = s.dir_level ? hjg_pkg::DIR_POS : hjg_pkg::DIR_NEG;
      edge_stamp = s.now_ms;
      if (!(edge_gap < 32'(win_reg) && kept_dir != d)) begin
        r.step_dir = d;
        kept_dir   = d;
      end
    end
    seen_clk = s.clk_level;
    // Accepted step past the hold-off: X over Y over Z
    if (r.step_dir != hjg_pkg::DIR_NONE && jog_gap >= hold_off) begin
      if (!s.x_button_n) begin
        axis = hjg_pkg::AXIS_X;
        feed = x_feed_reg;
      end else if (!s.y_button_n) begin
        axis = hjg_pkg::AXIS_Y;
        feed = y_feed_reg;
      end else if (!s.z_button_n) begin
        axis = hjg_pkg::AXIS_Z;
        feed = z_feed_reg;
      end else begin
        picked = 1'b0;
      end
      // No button or a zero feed issues nothing and leaves the jog history alone
      if (picked && feed != '0) begin
        r.jog_valid    = 1'b1;
        r.jog_axis     = axis;
        r.jog_negative = (r.step_dir == hjg_pkg::DIR_NEG);
        r.jog_feed     = feed;
        jog_stamp      = s.now_ms;
        hold_off       = (32'(dist_reg) * 32'(hjg_pkg::MS_PER_MINUTE)) / 32'(feed);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random gap, then hold the transaction until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_sample(hjg_pkg::in_item_t s, bit typed, hjg_pkg::out_item_t hand_result);
    int unsigned        gap;
    hjg_pkg::out_item_t predicted;
    gap = in_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    // Taken at this edge; the predictor runs regardless so its history stays in step
    predicted = predict_jog(s);
    expected_jogs.push_back(typed ? hand_result : predicted);
  endtask

  // Drop valid, wait for every result and for the divider to finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_jogs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers plus one unknown index; the block must be idle
  task automatic program_regs(logic [hjg_pkg::CFG_DATA_W-1:0] win,
                              logic [hjg_pkg::CFG_DATA_W-1:0] xf,
                              logic [hjg_pkg::CFG_DATA_W-1:0] yf,
                              logic [hjg_pkg::CFG_DATA_W-1:0] zf,
                              logic [hjg_pkg::CFG_DATA_W-1:0] jd);
    logic [hjg_pkg::CFG_IDX_W-1:0]  idx[6];
    logic [hjg_pkg::CFG_DATA_W-1:0] val[6];
    idx[0] = hjg_pkg::CFG_REV_WINDOW; val[0] = win;
    idx[1] = hjg_pkg::CFG_X_FEED;     val[1] = xf;
    idx[2] = hjg_pkg::CFG_Y_FEED;     val[2] = yf;
    idx[3] = hjg_pkg::CFG_Z_FEED;     val[3] = zf;
    idx[4] = hjg_pkg::CFG_JOG_DIST;   val[4] = jd;
    // Unused index: must not disturb anything
    idx[5] = hjg_pkg::CFG_JOG_DIST + hjg_pkg::CFG_IDX_W'($urandom_range(1, 3));
    val[5] = hjg_pkg::CFG_DATA_W'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      model_reg_write(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed rotation: alternate the clock line, keep a direction for a
  // burst with the odd reversal, hold a button pattern; the rest is noise.
  task automatic run_random(int unsigned n, int unsigned scale);
    hjg_pkg::in_item_t s;
    int unsigned       pick;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        s = '0;
        s.clk_level  = 1'($urandom_range(0, 1));
        s.dir_level  = 1'($urandom_range(0, 1));
        s.x_button_n = 1'($urandom_range(0, 1));
        s.y_button_n = 1'($urandom_range(0, 1));
        s.z_button_n = 1'($urandom_range(0, 1));
        s.now_ms     = $urandom;
      end else begin
        enc_clk = ~enc_clk;
        if ($urandom_range(0, 19) == 0) enc_dir = ~enc_dir;
        if ($urandom_range(0, 9) == 0) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1:    enc_btn_n = 3'b011;
            2, 3:    enc_btn_n = 3'b101;
            4, 5:    enc_btn_n = 3'b110;
            6:       enc_btn_n = 3'b000;
            7:       enc_btn_n = 3'b100;
            8:       enc_btn_n = 3'b111;
            default: enc_btn_n = 3'($urandom);
          endcase
        end
        if ($urandom_range(0, 9) == 0) enc_ms += $urandom_range(0, 8 * scale);
        else                          enc_ms += $urandom_range(0, scale);
        s.clk_level  = enc_clk;
        s.dir_level  = ($urandom_range(0, 5) == 0) ? ~enc_dir : enc_dir;
        s.x_button_n = enc_btn_n[2];
        s.y_button_n = enc_btn_n[1];
        s.z_button_n = enc_btn_n[0];
        s.now_ms     = enc_ms;
      end
      send_sample(s, 1'b0, '0);
    end
  endtask

  function automatic void add_row(bit c, bit d, logic [2:0] btn_n, logic [31:0] t_ms,
                                  bit typed, hjg_pkg::out_item_t r);
    sample_row_t row;
    row.sample.clk_level  = c;
    row.sample.dir_level  = d;
    row.sample.x_button_n = btn_n[2];
    row.sample.y_button_n = btn_n[1];
    row.sample.z_button_n = btn_n[0];
    row.sample.now_ms     = t_ms;
    row.typed             = typed;
    row.result            = r;
    sample_rows.push_back(row);
  endfunction

  // Random feed with a bias towards slow rates, where hold-offs matter
  function automatic logic [hjg_pkg::CFG_DATA_W-1:0] draw_feed();
    if ($urandom_range(0, 7) == 0) return '0;
    if ($urandom_range(0, 1) == 0) return hjg_pkg::CFG_DATA_W'($urandom_range(300, 5000));
    return hjg_pkg::CFG_DATA_W'($urandom_range(1, 65535));
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall per result, then compare with the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    forever begin
      hold = out_idle_on ? $urandom_range(0, 9) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    hjg_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_jogs.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, got %h", $time, out_item_o);
      end else begin
        want = expected_jogs.pop_front();
        check_field("step_dir",     32'(want.step_dir),     32'(out_item_o.step_dir));
        check_field("jog_valid",    32'(want.jog_valid),    32'(out_item_o.jog_valid));
        check_field("jog_axis",     32'(want.jog_axis),     32'(out_item_o.jog_axis));
        check_field("jog_negative", 32'(want.jog_negative), 32'(out_item_o.jog_negative));
        check_field("jog_feed",     32'(want.jog_feed),     32'(out_item_o.jog_feed));
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL handwheel_jog_generator");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    hjg_pkg::out_item_t none;
    none = '0;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings (window 50, X/Y 1000, Z 600, distance 1).
    // Buttons are {x, y, z}, active low.
    add_row(1'b1, 1'b1, 3'b011, 32'd0,   1'b1, none);  // clock high: no edge
    add_row(1'b0, 1'b1, 3'b011, 32'd10,  1'b1, none);  // first edge inside window: dropped
    add_row(1'b1, 1'b1, 3'b011, 32'd20,  1'b0, none);
    add_row(1'b0, 1'b1, 3'b011, 32'd100, 1'b1,
            hjg_pkg::out_item_t'{hjg_pkg::DIR_POS, 1'b1, hjg_pkg::AXIS_X, 1'b0,
                                 16'd1000});  // first jog, hold-off 60
    add_row(1'b1, 1'b1, 3'b011, 32'd110, 1'b0, none);
    add_row(1'b0, 1'b0, 3'b011, 32'd120, 1'b1, none);  // quick reversal: dropped
    add_row(1'b1, 1'b0, 3'b011, 32'd130, 1'b0, none);
    add_row(1'b0, 1'b1, 3'b011, 32'd140, 1'b0, none);  // same direction, hold-off blocks
    add_row(1'b1, 1'b1, 3'b011, 32'd150, 1'b0, none);
    add_row(1'b0, 1'b0, 3'b101, 32'd200, 1'b1,
            hjg_pkg::out_item_t'{hjg_pkg::DIR_NEG, 1'b1, hjg_pkg::AXIS_Y, 1'b1,
                                 16'd1000});  // Y, negative
    add_row(1'b1, 1'b0, 3'b110, 32'd210, 1'b0, none);
    add_row(1'b0, 1'b0, 3'b110, 32'd300, 1'b1,
            hjg_pkg::out_item_t'{hjg_pkg::DIR_NEG, 1'b1, hjg_pkg::AXIS_Z, 1'b1,
                                 16'd600});   // Z, hold-off 100
    add_row(1'b1, 1'b0, 3'b111, 32'd310, 1'b0, none);
    add_row(1'b0, 1'b0, 3'b111, 32'd450, 1'b1,
            hjg_pkg::out_item_t'{hjg_pkg::DIR_NEG, 1'b0, hjg_pkg::AXIS_X, 1'b0,
                                 16'd0});     // no button: step only
    add_row(1'b1, 1'b1, 3'b000, 32'd460, 1'b0, none);
    add_row(1'b0, 1'b1, 3'b000, 32'd600, 1'b0, none);  // all pressed: X wins
    add_row(1'b0, 1'b0, 3'b000, 32'd700, 1'b1, none);  // clock stays low: no edge
    add_row(1'b1, 1'b1, 3'b000, 32'hFFFF_FFF0, 1'b1, none);
    add_row(1'b0, 1'b1, 3'b001, 32'hFFFF_FFFF, 1'b0, none);  // timestamp at its top
    add_row(1'b1, 1'b0, 3'b110, 32'd0, 1'b0, none);
    add_row(1'b0, 1'b0, 3'b110, 32'h0000_0020, 1'b1, none);  // reversal across the wrap
    foreach (sample_rows[i]) send_sample(sample_rows[i].sample, sample_rows[i].typed,
                                         sample_rows[i].result);

    // Random part at the reset settings
    enc_clk   = 1'b1;
    enc_dir   = 1'b1;
    enc_btn_n = 3'b011;
    enc_ms    = 32'd1000;
    run_random(150, 60);

    // Window off, slowest X, fastest Y, zero Z, longest distance; no idling
    settle_block();
    program_regs(16'd0, 16'd1, 16'd65535, 16'd0, 16'd255);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_random(150, 300);

    // Window above 1000 (upper bits dropped), zero X feed, distance with upper bits set
    settle_block();
    program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFF01);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_random(150, 1500);

    // Zero distance: no hold-off at all
    settle_block();
    program_regs(16'd1000, draw_feed(), draw_feed(), draw_feed(), 16'hFF00);
    in_idle_on = 1'b0;
    run_random(150, 1200);

    // Random settings; the first run starts just below the timestamp wrap
    enc_ms = 32'hFFFF_F000;
    for (int p = 0; p < 3; p++) begin
      settle_block();
      program_regs(hjg_pkg::CFG_DATA_W'($urandom_range(0, 1023)), draw_feed(), draw_feed(),
                   draw_feed(), hjg_pkg::CFG_DATA_W'($urandom_range(0, 255)));
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      run_random(150, $urandom_range(20, 3000));
    end

    settle_block();
    if (mismatches == 0) begin
      $display("PASS handwheel_jog_generator");
    end else begin
      $display("FAIL handwheel_jog_generator");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hjg_pkg.sv
rtl/hjg_ctrl.sv
rtl/hjg_dp.sv
rtl/handwheel_jog_generator.sv
tb/tb_handwheel_jog_generator.sv
